### rtl/core/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the stream pattern replace block.
// ----------------------------------------------------------------------------
package spr_pkg;

  // most result beats that one input beat can cause
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = 4;
  localparam int POS_W       = 3;
  localparam int PAT_W       = 64;
  localparam int LEN_W       = 4;

  typedef enum logic [1:0] {
    CFG_SEARCH_PATTERN = 2'd0,
    CFG_SEARCH_LENGTH  = 2'd1,
    CFG_REPL_PATTERN   = 2'd2,
    CFG_REPL_LENGTH    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PAT_W-1:0] search_pattern;
    logic [LEN_W-1:0] search_len;
    logic [PAT_W-1:0] repl_pattern;
    logic [LEN_W-1:0] repl_len;
  } cfg_t;

  // results of one input beat, oldest in entry 0
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [CNT_W-1:0]            count;
    logic                        mark;
    logic                        last;
  } burst_t;

endpackage

### rtl/core/spr_window.sv
// ----------------------------------------------------------------------------
// spr_window
// Pending byte window, pattern compare and result list for one input beat.
// ----------------------------------------------------------------------------
module spr_window #(
  parameter int MAX_PATTERN = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spr_pkg::cfg_t   cfg_i,
  input  logic            accept_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output spr_pkg::burst_t burst_o
);

  localparam int FW = $clog2(MAX_PATTERN + 1);

  logic [MAX_PATTERN-1:0][7:0] win_q, win_d;
  logic [FW-1:0]               fill_q, fill_d;

  logic [MAX_PATTERN-1:0][7:0]      win_app;
  logic [spr_pkg::CNT_W-1:0]        fill_app;
  logic [spr_pkg::CNT_W-1:0]        slen, rlen, n_emit, e_part;
  logic                             over, at_len, match;

  always_comb begin
    // clamp lengths
    if (cfg_i.search_len > spr_pkg::LEN_W'(MAX_PATTERN)) begin
      slen = spr_pkg::CNT_W'(MAX_PATTERN);
    end else begin
      slen = spr_pkg::CNT_W'(cfg_i.search_len);
    end
    if (cfg_i.repl_len > spr_pkg::LEN_W'(spr_pkg::MAX_RESULTS)) begin
      rlen = spr_pkg::CNT_W'(spr_pkg::MAX_RESULTS);
    end else begin
      rlen = spr_pkg::CNT_W'(cfg_i.repl_len);
    end

    // append the new byte
    fill_app = spr_pkg::CNT_W'(fill_q) + spr_pkg::CNT_W'(1);
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (spr_pkg::CNT_W'(k) == spr_pkg::CNT_W'(fill_q)) begin
        win_app[k] = in_byte_i;
      end else begin
        win_app[k] = win_q[k];
      end
    end

    over   = fill_app > slen;
    at_len = (fill_app == slen) && (slen != '0);

    match = at_len;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if ((spr_pkg::CNT_W'(k) < slen) &&
          (win_app[k] != cfg_i.search_pattern[8*k +: 8])) begin
        match = 1'b0;
      end
    end

    if (over) begin
      e_part = (fill_app >= spr_pkg::CNT_W'(2)) ? spr_pkg::CNT_W'(2) : spr_pkg::CNT_W'(1);
    end else if (at_len) begin
      e_part = spr_pkg::CNT_W'(1);
    end else begin
      e_part = '0;
    end
    // a last beat flushes the whole window
    n_emit = in_last_i ? fill_app : e_part;

    // result list
    for (int i = 0; i < spr_pkg::MAX_RESULTS; i++) begin
      burst_o.bytes[i] = match ? cfg_i.repl_pattern[8*i +: 8] : 8'h00;
    end
    if (!match) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        burst_o.bytes[k] = win_app[k];
      end
    end
    burst_o.count = match ? rlen : n_emit;
    burst_o.mark  = 1'b0;
    burst_o.last  = in_last_i;
    if (in_last_i && (burst_o.count == '0)) begin
      // bare end mark
      burst_o.count    = spr_pkg::CNT_W'(1);
      burst_o.mark     = 1'b1;
      burst_o.bytes[0] = 8'h00;
    end

    // drop the emitted bytes from the window
    for (int k = 0; k < MAX_PATTERN; k++) begin
      win_d[k] = win_app[k];
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (spr_pkg::CNT_W'(j) == spr_pkg::CNT_W'(k) + n_emit) begin
          win_d[k] = win_app[j];
        end
      end
    end
    if (match || in_last_i) begin
      fill_d = '0;
    end else begin
      fill_d = FW'(fill_app - n_emit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (accept_i) begin
      fill_q <= fill_d;
    end
  end

endmodule

### rtl/core/spr_burst.sv
// ----------------------------------------------------------------------------
// spr_burst
// Result register that holds the list of one input beat and drains it.
// ----------------------------------------------------------------------------
module spr_burst (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  spr_pkg::burst_t burst_i,
  output logic            ready_o,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_valid_o,
  output logic            out_last_o
);

  logic [spr_pkg::MAX_RESULTS-1:0][7:0] bytes_q;
  logic [spr_pkg::CNT_W-1:0]            cnt_q;
  logic [spr_pkg::POS_W-1:0]            pos_q;
  logic                                 mark_q, last_q;
  logic                                 at_end, take;

  assign at_end      = (spr_pkg::CNT_W'(pos_q) + spr_pkg::CNT_W'(1)) == cnt_q;
  assign res_valid_o = cnt_q != '0;
  assign take        = res_valid_o && !res_stall_i;
  // free now, or the final beat of the list leaves this cycle
  assign ready_o     = !res_valid_o || (take && at_end);

  assign out_byte_o  = bytes_q[pos_q];
  assign out_valid_o = !mark_q;
  assign out_last_o  = last_q && at_end;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= burst_i.bytes;
      mark_q  <= burst_i.mark;
      last_q  <= burst_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      pos_q <= '0;
    end else if (load_i) begin
      cnt_q <= burst_i.count;
      pos_q <= '0;
    end else if (take) begin
      if (at_end) begin
        cnt_q <= '0;
        pos_q <= '0;
      end else begin
        pos_q <= pos_q + spr_pkg::POS_W'(1);
      end
    end
  end

  a_pos_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (spr_pkg::CNT_W'(pos_q) < cnt_q))
    else $error("result position beyond list");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= spr_pkg::CNT_W'(spr_pkg::MAX_RESULTS))
    else $error("result count too large");

  a_mark_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && mark_q) |-> (cnt_q == spr_pkg::CNT_W'(1) && last_q))
    else $error("end mark not a lone final beat");

  a_list_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !at_end) |=> res_valid_o)
    else $error("list dropped before its end");

endmodule

### rtl/core/stream_pattern_replace.sv
// ----------------------------------------------------------------------------
// stream_pattern_replace
// Byte stream search and replace with configurable search and replacement.
// ----------------------------------------------------------------------------
// first result beat: valid in the cycle after the input beat is accepted
// throughput: one input beat per cycle while each beat yields at most one result and the output is not stalled
// a beat yielding more than one result holds the input until the result
//   register has drained its list, one beat per cycle while not stalled
// reset clears the window fill, the result count and position, and all config registers
module stream_pattern_replace #(
  parameter int MAX_PATTERN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_valid_o,
  output logic        out_last_o
);

  spr_pkg::cfg_t   cfg_q;
  spr_pkg::burst_t burst;
  logic            ready, accept;

  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spr_pkg::CFG_SEARCH_PATTERN: cfg_q.search_pattern <= cfg_data_i;
        spr_pkg::CFG_SEARCH_LENGTH:  cfg_q.search_len <= cfg_data_i[spr_pkg::LEN_W-1:0];
        spr_pkg::CFG_REPL_PATTERN:   cfg_q.repl_pattern <= cfg_data_i;
        spr_pkg::CFG_REPL_LENGTH:    cfg_q.repl_len <= cfg_data_i[spr_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  spr_window #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .in_byte_i (in_byte_i),
    .in_last_i (in_last_i),
    .burst_o   (burst)
  );

  spr_burst u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .burst_i     (burst),
    .ready_o     (ready),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .out_last_o  (out_last_o)
  );

endmodule
